### hw/rtl/icp_pkg.sv
// icp_pkg: shared types and constants for the incident capture trigger policy
// holds stall kind codes, register indexes and the transaction payload structs
// no dependencies
package icp_pkg;

    localparam logic [7:0] KIND_HEALTHY = 8'd0;
    localparam logic [7:0] KIND_HARD    = 8'd1;
    localparam logic [7:0] KIND_STORM   = 8'd2;
    localparam logic [7:0] KIND_SLOW    = 8'd3;
    localparam logic [7:0] KIND_SPIN    = 8'd5;

    localparam logic [2:0] PEND_NONE  = 3'd0;
    localparam logic [2:0] PEND_HARD  = 3'd1;
    localparam logic [2:0] PEND_STORM = 3'd2;
    localparam logic [2:0] PEND_SLOW  = 3'd3;
    localparam logic [2:0] PEND_SPIN  = 3'd5;

    localparam logic       REQ_OBSERVE = 1'b0;
    localparam logic       REQ_OUTCOME = 1'b1;

    localparam logic       REG_REARM_TICK_COUNT = 1'b0;
    localparam logic       REG_MAX_FAIL_COUNT   = 1'b1;

    localparam logic [15:0] REARM_TICK_RESET = 16'd60;
    localparam logic [7:0]  MAX_FAIL_RESET   = 8'd3;
    localparam logic [7:0]  FAIL_RUN_MAX     = 8'hff;

    typedef struct packed {
        logic       req_type;
        logic [7:0] stall_kind;
        logic       fatal_flag;
        logic       capture_written;
    } icp_in_t;

    typedef struct packed {
        logic        capture_request;
        logic [2:0]  request_kind;
        logic [31:0] suppressed_total;
        logic [31:0] written_total;
        logic [31:0] failed_total;
    } icp_out_t;

endpackage

### hw/rtl/incident_capture_trigger_policy.sv
// incident_capture_trigger_policy: decides when to request a one-shot capture
// policy state, counters and a two-entry output stage
// depends on icp_pkg
//
// One transaction is accepted per cycle while in_ready is high. Its result is
// registered in the result register, or in the skid register if the output
// stalls. Policy state updates at acceptance, so each item sees the state left
// by the previous one. The skid entry lets input keep flowing while one
// result waits; in_ready drops only when both entries are full. Every input
// transaction yields exactly one result transaction. Configuration writes via
// cfg_write take effect at the next clock edge and should be made while idle.
module incident_capture_trigger_policy
    import icp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  icp_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output icp_out_t    out_data
);

    logic [15:0] rearm_tick_reg;
    logic [7:0]  max_fail_reg;

    logic        incident_open_reg, incident_open_next;
    logic [2:0]  incident_kind_reg, incident_kind_next;
    logic [15:0] healthy_run_reg,   healthy_run_next;
    logic [2:0]  pending_kind_reg,  pending_kind_next;
    logic        hard_used_reg,     hard_used_next;
    logic        other_used_reg,    other_used_next;
    logic [7:0]  hard_fail_reg,     hard_fail_next;
    logic [7:0]  other_fail_reg,    other_fail_next;
    logic [31:0] suppressed_reg,    suppressed_next;
    logic [31:0] written_reg,       written_next;
    logic [31:0] failed_reg,        failed_next;
    logic        request;

    logic        out_valid_reg;
    icp_out_t    out_data_reg;
    logic        skid_valid_reg;
    icp_out_t    skid_data_reg;

    logic        in_fire;
    logic        kind_known;
    logic        is_hard;
    logic        pend_hard;
    logic [15:0] healthy_inc;
    logic [7:0]  hard_fail_inc;
    logic [7:0]  other_fail_inc;
    icp_out_t    result;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    assign kind_known = (in_data.stall_kind == KIND_HARD) || (in_data.stall_kind == KIND_STORM)
                     || (in_data.stall_kind == KIND_SLOW) || (in_data.stall_kind == KIND_SPIN);
    assign is_hard     = in_data.stall_kind == KIND_HARD;
    assign pend_hard   = pending_kind_reg == PEND_HARD;
    assign healthy_inc = healthy_run_reg + 16'd1;
    assign hard_fail_inc  = (hard_fail_reg == FAIL_RUN_MAX) ? hard_fail_reg
                                                            : hard_fail_reg + 8'd1;
    assign other_fail_inc = (other_fail_reg == FAIL_RUN_MAX) ? other_fail_reg
                                                             : other_fail_reg + 8'd1;

    always_comb
    begin
        incident_open_next = incident_open_reg;
        incident_kind_next = incident_kind_reg;
        healthy_run_next   = healthy_run_reg;
        pending_kind_next  = pending_kind_reg;
        hard_used_next     = hard_used_reg;
        other_used_next    = other_used_reg;
        hard_fail_next     = hard_fail_reg;
        other_fail_next    = other_fail_reg;
        suppressed_next    = suppressed_reg;
        written_next       = written_reg;
        failed_next        = failed_reg;
        request            = 1'b0;

        if (in_data.req_type == REQ_OBSERVE)
        begin
            if (!in_data.fatal_flag)
            begin
                if (in_data.stall_kind != KIND_HEALTHY)
                begin
                    if (kind_known)
                    begin
                        healthy_run_next = '0;
                        // only a hard stall escalates an open non-hard incident
                        if (!incident_open_reg || (is_hard && incident_kind_reg != PEND_HARD))
                        begin
                            incident_open_next = 1'b1;
                            incident_kind_next = in_data.stall_kind[2:0];
                            if (is_hard ? !hard_used_reg : !other_used_reg)
                            begin
                                pending_kind_next = in_data.stall_kind[2:0];
                                request           = 1'b1;
                            end
                            else
                            begin
                                suppressed_next = suppressed_reg + 32'd1;
                            end
                        end
                    end
                end
                else if (incident_open_reg)
                begin
                    healthy_run_next = healthy_inc;
                    if (healthy_inc >= rearm_tick_reg)
                    begin
                        healthy_run_next   = '0;
                        incident_kind_next = PEND_NONE;
                        incident_open_next = 1'b0;
                    end
                end
            end
        end
        else if (pending_kind_reg != PEND_NONE)
        begin
            if (in_data.capture_written)
            begin
                if (pend_hard)
                    hard_used_next = 1'b1;
                else
                    other_used_next = 1'b1;
                written_next = written_reg + 32'd1;
            end
            else
            begin
                failed_next = failed_reg + 32'd1;
                if (pend_hard)
                begin
                    hard_fail_next = hard_fail_inc;
                    if (hard_fail_inc >= max_fail_reg)
                        hard_used_next = 1'b1;
                end
                else
                begin
                    other_fail_next = other_fail_inc;
                    if (other_fail_inc >= max_fail_reg)
                        other_used_next = 1'b1;
                end
                healthy_run_next   = '0;
                incident_kind_next = PEND_NONE;
                incident_open_next = 1'b0;
            end
            pending_kind_next = PEND_NONE;
        end
    end

    always_comb
    begin
        result.capture_request  = request;
        result.request_kind     = pending_kind_next;
        result.suppressed_total = suppressed_next;
        result.written_total    = written_next;
        result.failed_total     = failed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rearm_tick_reg <= REARM_TICK_RESET;
            max_fail_reg   <= MAX_FAIL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_REARM_TICK_COUNT: rearm_tick_reg <= cfg_data;
                REG_MAX_FAIL_COUNT:   max_fail_reg   <= cfg_data[7:0];
                default:              max_fail_reg   <= max_fail_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            incident_open_reg <= 1'b0;
            incident_kind_reg <= '0;
            healthy_run_reg   <= '0;
            pending_kind_reg  <= '0;
            hard_used_reg     <= 1'b0;
            other_used_reg    <= 1'b0;
            hard_fail_reg     <= '0;
            other_fail_reg    <= '0;
            suppressed_reg    <= '0;
            written_reg       <= '0;
            failed_reg        <= '0;
        end
        else if (in_fire)
        begin
            incident_open_reg <= incident_open_next;
            incident_kind_reg <= incident_kind_next;
            healthy_run_reg   <= healthy_run_next;
            pending_kind_reg  <= pending_kind_next;
            hard_used_reg     <= hard_used_next;
            other_used_reg    <= other_used_next;
            hard_fail_reg     <= hard_fail_next;
            other_fail_reg    <= other_fail_next;
            suppressed_reg    <= suppressed_next;
            written_reg       <= written_next;
            failed_reg        <= failed_next;
        end
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else if (in_fire)
                out_data_reg <= result;
        end
        else if (in_fire)
        begin
            skid_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry full while output register empty");

    a_request_has_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.capture_request)
        |-> (out_data_reg.request_kind != PEND_NONE))
        else $error("capture request without a pending kind");

    a_pending_known: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_kind_reg == PEND_NONE) || (pending_kind_reg == PEND_HARD)
        || (pending_kind_reg == PEND_STORM) || (pending_kind_reg == PEND_SLOW)
        || (pending_kind_reg == PEND_SPIN))
        else $error("pending kind is not a known stall kind");

    a_closed_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !incident_open_reg |-> (healthy_run_reg == '0 && incident_kind_reg == PEND_NONE))
        else $error("closed incident left stale state");

endmodule

### sim/tb.sv
// tb: self-checking testbench for incident_capture_trigger_policy
// drives directed and random observe and outcome transactions and checks each result
// depends on icp_pkg and the incident_capture_trigger_policy rtl
module tb
    import icp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_GAP     = 40;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic        cfg_index = REG_REARM_TICK_COUNT;
    logic [15:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    icp_in_t     in_data   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    icp_out_t    out_data;

    // policy shadow state
    logic        inc_open;
    logic [2:0]  inc_kind;
    logic [15:0] healthy_cnt;
    logic [2:0]  pend_kind;
    logic        hard_used;
    logic        other_used;
    logic [7:0]  hard_fails;
    logic [7:0]  other_fails;
    logic [31:0] suppressed_cnt;
    logic [31:0] written_cnt;
    logic [31:0] failed_cnt;
    logic [15:0] rearm_ticks;
    logic [7:0]  fail_limit;

    icp_out_t    expected_results[$];
    int          mismatch_count = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_left      = 0;

    incident_capture_trigger_policy DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: long hold-off first, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        icp_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transaction with no expectation waiting");
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.capture_request !== want.capture_request)
                begin
                    $error("capture_request: expected %0d, actual %0d",
                           want.capture_request, out_data.capture_request);
                    mismatch_count++;
                end
                if (out_data.request_kind !== want.request_kind)
                begin
                    $error("request_kind: expected %0d, actual %0d",
                           want.request_kind, out_data.request_kind);
                    mismatch_count++;
                end
                if (out_data.suppressed_total !== want.suppressed_total)
                begin
                    $error("suppressed_total: expected %0d, actual %0d",
                           want.suppressed_total, out_data.suppressed_total);
                    mismatch_count++;
                end
                if (out_data.written_total !== want.written_total)
                begin
                    $error("written_total: expected %0d, actual %0d",
                           want.written_total, out_data.written_total);
                    mismatch_count++;
                end
                if (out_data.failed_total !== want.failed_total)
                begin
                    $error("failed_total: expected %0d, actual %0d",
                           want.failed_total, out_data.failed_total);
                    mismatch_count++;
                end
            end
        end
    end

    function automatic logic is_known_kind(input logic [7:0] k);
        return k == KIND_HARD || k == KIND_STORM || k == KIND_SLOW || k == KIND_SPIN;
    endfunction

    // advances the shadow policy state by one transaction and returns its result
    function automatic icp_out_t policy_step(input icp_in_t t);
        icp_out_t r;
        logic     request;
        logic     hard;
        request = 1'b0;
        if (t.req_type == REQ_OBSERVE)
        begin
            if (!t.fatal_flag)
            begin
                if (t.stall_kind != KIND_HEALTHY)
                begin
                    if (is_known_kind(t.stall_kind))
                    begin
                        healthy_cnt = '0;
                        if (!(inc_open && (t.stall_kind != KIND_HARD
                                           || inc_kind == PEND_HARD)))
                        begin
                            inc_open = 1'b1;
                            inc_kind = t.stall_kind[2:0];
                            if (t.stall_kind == KIND_HARD ? !hard_used : !other_used)
                            begin
                                pend_kind = t.stall_kind[2:0];
                                request   = 1'b1;
                            end
                            else
                            begin
                                suppressed_cnt = suppressed_cnt + 32'd1;
                            end
                        end
                    end
                end
                else if (inc_open)
                begin
                    healthy_cnt = healthy_cnt + 16'd1;
                    if (healthy_cnt >= rearm_ticks)
                    begin
                        healthy_cnt = '0;
                        inc_kind    = PEND_NONE;
                        inc_open    = 1'b0;
                    end
                end
            end
        end
        else if (pend_kind != PEND_NONE)
        begin
            hard = (pend_kind == PEND_HARD);
            if (t.capture_written)
            begin
                if (hard)
                    hard_used = 1'b1;
                else
                    other_used = 1'b1;
                written_cnt = written_cnt + 32'd1;
            end
            else
            begin
                failed_cnt = failed_cnt + 32'd1;
                if (hard)
                begin
                    if (hard_fails != FAIL_RUN_MAX)
                        hard_fails = hard_fails + 8'd1;
                    if (hard_fails >= fail_limit)
                        hard_used = 1'b1;
                end
                else
                begin
                    if (other_fails != FAIL_RUN_MAX)
                        other_fails = other_fails + 8'd1;
                    if (other_fails >= fail_limit)
                        other_used = 1'b1;
                end
                healthy_cnt = '0;
                inc_kind    = PEND_NONE;
                inc_open    = 1'b0;
            end
            pend_kind = PEND_NONE;
        end
        r.capture_request  = request;
        r.request_kind     = pend_kind;
        r.suppressed_total = suppressed_cnt;
        r.written_total    = written_cnt;
        r.failed_total     = failed_cnt;
        return r;
    endfunction

    function automatic icp_in_t obs_txn(input logic [7:0] kind, input logic fatal);
        icp_in_t t;
        t.req_type        = REQ_OBSERVE;
        t.stall_kind      = kind;
        t.fatal_flag      = fatal;
        t.capture_written = 1'($urandom_range(1));
        return t;
    endfunction

    function automatic icp_in_t outcome_txn(input logic written);
        icp_in_t t;
        t.req_type        = REQ_OUTCOME;
        t.stall_kind      = 8'($urandom_range(255));
        t.fatal_flag      = 1'($urandom_range(1));
        t.capture_written = written;
        return t;
    endfunction

    function automatic logic [7:0] pick_stall_kind();
        case ($urandom_range(3))
            0: return KIND_HARD;
            1: return KIND_STORM;
            2: return KIND_SLOW;
            default: return KIND_SPIN;
        endcase
    endfunction

    function automatic icp_in_t random_txn(input logic allow_success);
        int r;
        r = $urandom_range(99);
        if (r < 40)
            return obs_txn(pick_stall_kind(), 1'b0);
        else if (r < 68)
            return obs_txn(KIND_HEALTHY, 1'b0);
        else if (r < 88)
            return outcome_txn(allow_success ? 1'($urandom_range(1)) : 1'b0);
        else if (r < 94)
            return obs_txn(8'($urandom_range(255)), 1'b0);
        else
            return obs_txn(8'($urandom_range(255)), 1'b1);
    endfunction

    task automatic send_txn(input icp_in_t t);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_results.push_back(policy_step(t));
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_REARM_TICK_COUNT)
            rearm_ticks = val;
        else
            fail_limit = val[7:0];
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic run_traffic(input int n, input logic allow_success);
        repeat (n) send_txn(random_txn(allow_success));
        drain();
    endtask

    task automatic test_ignored_items();
        set_idle(0, 0);
        send_txn(obs_txn(KIND_HARD, 1'b1));
        send_txn(obs_txn(KIND_HEALTHY, 1'b1));
        send_txn(obs_txn(8'd4, 1'b0));
        send_txn(obs_txn(8'd255, 1'b0));
        send_txn(obs_txn(8'd6, 1'b0));
        send_txn(obs_txn(KIND_HEALTHY, 1'b0));
        send_txn(outcome_txn(1'b1));
        send_txn(outcome_txn(1'b0));
        drain();
    endtask

    task automatic test_capture_and_escalation();
        write_reg(REG_MAX_FAIL_COUNT, 16'd255);
        write_reg(REG_REARM_TICK_COUNT, 16'd2);
        send_txn(obs_txn(KIND_STORM, 1'b0));
        send_txn(obs_txn(KIND_HARD, 1'b0));
        send_txn(obs_txn(KIND_HARD, 1'b0));
        send_txn(obs_txn(KIND_SLOW, 1'b0));
        send_txn(outcome_txn(1'b0));
        send_txn(obs_txn(KIND_SPIN, 1'b0));
        send_txn(obs_txn(KIND_HEALTHY, 1'b0));
        send_txn(obs_txn(KIND_HEALTHY, 1'b0));
        send_txn(obs_txn(KIND_SLOW, 1'b0));
        send_txn(outcome_txn(1'b0));
        drain();
    endtask

    task automatic test_rearm_extremes();
        write_reg(REG_REARM_TICK_COUNT, 16'd0);
        send_txn(obs_txn(KIND_HARD, 1'b0));
        send_txn(obs_txn(KIND_HEALTHY, 1'b0));
        send_txn(obs_txn(KIND_STORM, 1'b0));
        send_txn(outcome_txn(1'b0));
        drain();
        write_reg(REG_REARM_TICK_COUNT, 16'hffff);
        send_txn(obs_txn(KIND_SPIN, 1'b0));
        repeat (3) send_txn(obs_txn(KIND_HEALTHY, 1'b0));
        send_txn(obs_txn(KIND_HARD, 1'b0));
        send_txn(outcome_txn(1'b0));
        drain();
    endtask

    task automatic test_random_traffic();
        write_reg(REG_REARM_TICK_COUNT, 16'($urandom_range(1, 4)));
        set_idle(0, 0);
        run_traffic(300, 1'b0);
        write_reg(REG_REARM_TICK_COUNT, 16'($urandom_range(1, 4)));
        set_idle(83, 0);
        run_traffic(300, 1'b0);
        write_reg(REG_REARM_TICK_COUNT, 16'($urandom_range(1, 4)));
        set_idle(0, 83);
        run_traffic(300, 1'b0);
        write_reg(REG_REARM_TICK_COUNT, 16'($urandom_range(1, 4)));
        set_idle(8, 8);
        run_traffic(300, 1'b0);
    endtask

    task automatic test_backpressure();
        write_reg(REG_REARM_TICK_COUNT, 16'd3);
        set_idle(0, 0);
        hold_left = 200;
        repeat (24) send_txn(random_txn(1'b0));
        drain();
        hold_left = 150;
        repeat (24) send_txn(random_txn(1'b0));
        drain();
    endtask

    task automatic test_slot_exhaustion();
        write_reg(REG_MAX_FAIL_COUNT, 16'd1);
        write_reg(REG_REARM_TICK_COUNT, 16'd3);
        set_idle(8, 8);
        run_traffic(150, 1'b1);
        write_reg(REG_MAX_FAIL_COUNT, 16'd0);
        set_idle(0, 83);
        run_traffic(100, 1'b1);
        write_reg(REG_REARM_TICK_COUNT, 16'hffff);
        set_idle(0, 0);
        run_traffic(50, 1'b1);
        write_reg(REG_REARM_TICK_COUNT, 16'd1);
        set_idle(83, 0);
        run_traffic(50, 1'b1);
    endtask

    initial
    begin
        inc_open       = 1'b0;
        inc_kind       = PEND_NONE;
        healthy_cnt    = '0;
        pend_kind      = PEND_NONE;
        hard_used      = 1'b0;
        other_used     = 1'b0;
        hard_fails     = '0;
        other_fails    = '0;
        suppressed_cnt = '0;
        written_cnt    = '0;
        failed_cnt     = '0;
        rearm_ticks    = REARM_TICK_RESET;
        fail_limit     = MAX_FAIL_RESET;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_ignored_items();
        test_capture_and_escalation();
        test_rearm_extremes();
        test_random_traffic();
        test_backpressure();
        test_slot_exhaustion();

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
